// File: rtl/core/lpg_pkg.sv
// Package for the line pixel generator: coordinate widths, the segment
// descriptor that travels from the front to the back, and queue sizing.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package lpg_pkg;

   // Coordinate and decision widths are fixed by the pixel format.
   localparam int COORD_W        = 6;
   localparam int DEC_W          = 8;
   localparam int FRAME_SIZE_DEF = 64;

   // Depth of the descriptor queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Stepping directions and major axis of one segment.
   typedef struct packed {
      logic ymajor;
      logic yneg;
      logic xneg;
   } dir_type;

   // Everything the back needs to walk one segment.
   typedef struct packed {
      logic [COORD_W-1:0]    start_x;
      logic [COORD_W-1:0]    start_y;
      logic [COORD_W-1:0]    major;
      logic signed [DEC_W-1:0] dec_init;
      logic signed [DEC_W-1:0] inc_straight;
      logic signed [DEC_W-1:0] inc_diag;
      dir_type               dir;
   } seg_type;

endpackage

`default_nettype wire

// File: rtl/core/lpg_req_if.sv
// Input channel of the line pixel generator: one word is one segment.
// Depends on lpg_pkg for the coordinate width.
`default_nettype none

interface lpg_req_if
   import lpg_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] start_x;
   logic [COORD_W-1:0] start_y;
   logic [COORD_W-1:0] end_x;
   logic [COORD_W-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lpg_rsp_if.sv
// Result channel of the line pixel generator: one word is one pixel.
// Depends on lpg_pkg for the coordinate width.
`default_nettype none

interface lpg_rsp_if
   import lpg_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] pixel_x;
   logic [COORD_W-1:0] pixel_y;
   logic               last;

   modport source (output valid, pixel_x, pixel_y, last, input ready);
   modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/lpg_front.sv
// Front of the line pixel generator: accepts segments, clamps them to the
// frame and classifies them into a descriptor. Depends on lpg_pkg, lpg_req_if.
`default_nettype none

module lpg_front
   import lpg_pkg::*;
#(
   parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
   lpg_req_if.sink        req,
   input  wire logic      queue_full,
   output logic           push,
   output seg_type        seg
);

   localparam logic [COORD_W-1:0] MaxCoord = COORD_W'(FRAME_SIZE - 1);

   logic [COORD_W-1:0] sx;
   logic [COORD_W-1:0] sy;
   logic [COORD_W-1:0] ex;
   logic [COORD_W-1:0] ey;
   logic               xneg;
   logic               yneg;
   logic               ymajor;
   logic [COORD_W-1:0] abs_dx;
   logic [COORD_W-1:0] abs_dy;
   logic [COORD_W-1:0] major;
   logic [COORD_W-1:0] minor;
   logic [DEC_W-1:0]   minor2;
   logic [DEC_W-1:0]   major2;

   // Any coordinate beyond the frame saturates to its last pixel.
   assign sx = (req.start_x > MaxCoord) ? MaxCoord : req.start_x;
   assign sy = (req.start_y > MaxCoord) ? MaxCoord : req.start_y;
   assign ex = (req.end_x   > MaxCoord) ? MaxCoord : req.end_x;
   assign ey = (req.end_y   > MaxCoord) ? MaxCoord : req.end_y;

   // Deltas, directions and the major axis; equal deltas pick y as major.
   assign xneg   = ex < sx;
   assign yneg   = ey < sy;
   assign abs_dx = xneg ? (sx - ex) : (ex - sx);
   assign abs_dy = yneg ? (sy - ey) : (ey - sy);
   assign ymajor = !(abs_dx > abs_dy);
   assign major  = ymajor ? abs_dy : abs_dx;
   assign minor  = ymajor ? abs_dx : abs_dy;

   // Doubled deltas for the midpoint decision terms.
   assign minor2 = {1'b0, minor, 1'b0};
   assign major2 = {1'b0, major, 1'b0};

   // Build the descriptor.
   always_comb begin
      seg.start_x      = sx;
      seg.start_y      = sy;
      seg.major        = major;
      seg.dec_init     = minor2 - {2'b00, major};
      seg.inc_straight = minor2;
      seg.inc_diag     = minor2 - major2;
      seg.dir.ymajor   = ymajor;
      seg.dir.yneg     = yneg;
      seg.dir.xneg     = xneg;
   end

   // A segment is taken whenever the queue has room.
   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

endmodule

`default_nettype wire

// File: rtl/core/lpg_queue.sv
// Short descriptor queue between the front and the back of the line pixel
// generator. Depends on lpg_pkg for the descriptor type and depth.
`default_nettype none

module lpg_queue
   import lpg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire seg_type push_seg,
   input  wire logic    pop,
   output seg_type      head,
   output logic         full,
   output logic         empty
);

   localparam logic [QPTR_W-1:0] LastPtr = QPTR_W'(QUEUE_DEPTH - 1);
   localparam logic [QCNT_W-1:0] DepthCnt = QCNT_W'(QUEUE_DEPTH);

   seg_type           mem [QUEUE_DEPTH];
   seg_type           head_ff;
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_in;
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   assign full  = count_ff == DepthCnt;
   assign empty = count_ff == '0;
   assign head  = head_ff;

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Descriptor storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_seg;
      end
   end

   // Registered read at the next read address, so the head always shows the
   // oldest entry; a word written into that slot in the same cycle is passed on.
   always_ff @(posedge clock) begin
      if (push && (wr_ptr_ff == rd_ptr_in)) begin
         head_ff <= push_seg;
      end else begin
         head_ff <= mem[rd_ptr_in];
      end
   end

   // The front never writes a full queue and the back never reads an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff < DepthCnt))
      else $error("descriptor queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> (count_ff != '0))
      else $error("descriptor queue read while empty");

endmodule

`default_nettype wire

// File: rtl/core/lpg_back.sv
// Back of the line pixel generator: walks one segment descriptor at a time
// and emits one pixel word per cycle from its output register when rsp
// is ready. Depends on lpg_pkg and lpg_rsp_if.
`default_nettype none

module lpg_back
   import lpg_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire seg_type head,
   input  wire logic    empty,
   output logic         pop,
   lpg_rsp_if.source    rsp
);

   logic                    active_ff;
   logic                    active_in;
   logic [COORD_W-1:0]      cur_x_ff;
   logic [COORD_W-1:0]      cur_x_in;
   logic [COORD_W-1:0]      cur_y_ff;
   logic [COORD_W-1:0]      cur_y_in;
   logic signed [DEC_W-1:0] dec_ff;
   logic signed [DEC_W-1:0] dec_in;
   logic [COORD_W-1:0]      steps_ff;
   logic [COORD_W-1:0]      steps_in;
   logic signed [DEC_W-1:0] inc_straight_ff;
   logic signed [DEC_W-1:0] inc_straight_in;
   logic signed [DEC_W-1:0] inc_diag_ff;
   logic signed [DEC_W-1:0] inc_diag_in;
   dir_type                 dir_ff;
   dir_type                 dir_in;
   logic                    fire;
   logic                    done;
   logic                    step_minor;
   logic                    move_x;
   logic                    move_y;

   // The held pixel is the output word.
   assign rsp.valid   = active_ff;
   assign rsp.pixel_x = cur_x_ff;
   assign rsp.pixel_y = cur_y_ff;
   assign rsp.last    = steps_ff == '0;

   assign fire = active_ff && rsp.ready;
   assign done = fire && (steps_ff == '0);
   assign pop  = !empty && (!active_ff || done);

   // The minor axis steps when the decision is zero or positive.
   assign step_minor = !dec_ff[DEC_W-1];
   assign move_x     = !dir_ff.ymajor || step_minor;
   assign move_y     = dir_ff.ymajor || step_minor;

   // Load a new segment, take one step, or go idle after the end point.
   always_comb begin
      active_in       = active_ff;
      cur_x_in        = cur_x_ff;
      cur_y_in        = cur_y_ff;
      dec_in          = dec_ff;
      steps_in        = steps_ff;
      inc_straight_in = inc_straight_ff;
      inc_diag_in     = inc_diag_ff;
      dir_in          = dir_ff;
      if (pop) begin
         active_in       = 1'b1;
         cur_x_in        = head.start_x;
         cur_y_in        = head.start_y;
         dec_in          = head.dec_init;
         steps_in        = head.major;
         inc_straight_in = head.inc_straight;
         inc_diag_in     = head.inc_diag;
         dir_in          = head.dir;
      end else if (done) begin
         active_in = 1'b0;
      end else if (fire) begin
         if (move_x) begin
            cur_x_in = dir_ff.xneg ? (cur_x_ff - 1'b1) : (cur_x_ff + 1'b1);
         end
         if (move_y) begin
            cur_y_in = dir_ff.yneg ? (cur_y_ff - 1'b1) : (cur_y_ff + 1'b1);
         end
         dec_in   = dec_ff + (step_minor ? inc_diag_ff : inc_straight_ff);
         steps_in = steps_ff - 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         steps_ff  <= '0;
      end else begin
         active_ff <= active_in;
         steps_ff  <= steps_in;
      end
   end

   // Segment payload.
   always_ff @(posedge clock) begin
      cur_x_ff        <= cur_x_in;
      cur_y_ff        <= cur_y_in;
      dec_ff          <= dec_in;
      inc_straight_ff <= inc_straight_in;
      inc_diag_ff     <= inc_diag_in;
      dir_ff          <= dir_in;
   end

   // A pixel that is not the end point is always followed at once by another.
   a_run_continues: assert property (@(posedge clock) disable iff (reset)
      (fire && !rsp.last) |=> rsp.valid)
      else $error("segment run broke off before its end point");

   // Every step moves along the major axis, so the pixel always changes.
   a_pixel_moves: assert property (@(posedge clock) disable iff (reset)
      (fire && !rsp.last) |=> ((cur_x_ff != $past(cur_x_ff)) ||
                               (cur_y_ff != $past(cur_y_ff))))
      else $error("step did not move the pixel");

   // The decision value never reaches the negative end of its signed range.
   a_dec_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (dec_ff != {1'b1, {(DEC_W-1){1'b0}}}))
      else $error("decision value reached the end of its range");

endmodule

`default_nettype wire

// File: rtl/core/line_pixel_generator.sv
// Top level of the line pixel generator: front, descriptor queue and back.
// Depends on lpg_pkg, lpg_req_if, lpg_rsp_if, lpg_front, lpg_queue, lpg_back.
//
//   Channel   Direction  Word                              Handshake
//   req_chan  in         start_x, start_y, end_x, end_y    valid/ready
//   rsp_chan  out        pixel_x, pixel_y, last            valid/ready
//
// A segment gives max(|dx|,|dy|)+1 pixel words, 1 to 64 of them, one per
// cycle from the back's output register while rsp_chan is ready.
// On its way out a segment passes the queue head and back output registers.
// The queue holds two classified segments, so while the back stalls the front
// takes words until it is full; the back moves to the next segment with no gap.
// Reset is synchronous and empties the queue and the back.
`default_nettype none

module line_pixel_generator
   import lpg_pkg::*;
#(
   parameter int FRAME_SIZE = FRAME_SIZE_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lpg_req_if.sink    req_chan,
   lpg_rsp_if.source  rsp_chan
);

   logic    push;
   logic    pop;
   logic    full;
   logic    empty;
   seg_type push_seg;
   seg_type head;

   // Accept and classify segments.
   lpg_front #(
      .FRAME_SIZE (FRAME_SIZE)
   ) u_front (
      .req        (req_chan),
      .queue_full (full),
      .push       (push),
      .seg        (push_seg)
   );

   // Decouple the front from the back.
   lpg_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_seg (push_seg),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   // Walk each segment and emit its pixels.
   lpg_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

`default_nettype wire

// File: test/tb_line_pixel_generator.sv
// Testbench for line_pixel_generator: drives segments with random gaps and checks every
// pixel word against a built-in Bresenham model kept in a small scoreboard class.
// Depends on lpg_pkg, lpg_req_if, lpg_rsp_if and the line_pixel_generator RTL.
module tb_line_pixel_generator;
   timeunit 1ns;
   timeprecision 1ps;

   import lpg_pkg::*;

   localparam int FRAME_SIZE   = FRAME_SIZE_DEF;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_LINES = 450;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } segment_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      logic      last;
   } pixel_type;

   // Scoreboard: rasterizes each accepted segment and checks the pixel words in order.
   class line_scoreboard;
      pixel_type pixels_due[$];
      int        mismatches;
      coord_type pen_x;
      coord_type pen_y;
      int        error_term;

      function new();
         mismatches = 0;
         pen_x      = '0;
         pen_y      = '0;
         error_term = 0;
      endfunction

      function coord_type saturate_coord(coord_type v);
         return (int'(v) > FRAME_SIZE - 1) ? coord_type'(FRAME_SIZE - 1) : v;
      endfunction

      // Midpoint rule: the start pixel, then one pixel per major-axis step.
      function void rasterize_segment(segment_type seg);
         coord_type sx;
         coord_type sy;
         coord_type ex;
         coord_type ey;
         coord_type span_x;
         coord_type span_y;
         coord_type major;
         coord_type minor;
         dir_type   dir;
         int        steps;
         logic      diag;
         sx = saturate_coord(seg.sx);
         sy = saturate_coord(seg.sy);
         ex = saturate_coord(seg.ex);
         ey = saturate_coord(seg.ey);
         dir.xneg   = ex < sx;
         dir.yneg   = ey < sy;
         span_x     = dir.xneg ? sx - ex : ex - sx;
         span_y     = dir.yneg ? sy - ey : ey - sy;
         dir.ymajor = !(span_x > span_y);
         major      = dir.ymajor ? span_y : span_x;
         minor      = dir.ymajor ? span_x : span_y;
         pen_x      = sx;
         pen_y      = sy;
         error_term = 2 * int'(minor) - int'(major);
         steps      = int'(major);
         pixels_due.push_back('{x: pen_x, y: pen_y, last: steps == 0});
         while (steps != 0) begin
            diag = error_term >= 0;
            if (dir.ymajor || diag) begin
               pen_y = dir.yneg ? pen_y - 1'b1 : pen_y + 1'b1;
            end
            if (!dir.ymajor || diag) begin
               pen_x = dir.xneg ? pen_x - 1'b1 : pen_x + 1'b1;
            end
            if (diag) begin
               error_term += 2 * (int'(minor) - int'(major));
            end else begin
               error_term += 2 * int'(minor);
            end
            steps--;
            pixels_due.push_back('{x: pen_x, y: pen_y, last: steps == 0});
         end
      endfunction

      function int pending();
         return pixels_due.size();
      endfunction

      task report_mismatch(string what);
         if (mismatches < 40) begin
            $display("[%0t] mismatch: %s", $realtime, what);
         end
         mismatches++;
      endtask

      task check_pixel(coord_type x, coord_type y, logic last);
         pixel_type want;
         if (pixels_due.size() == 0) begin
            report_mismatch($sformatf("unexpected pixel word (%0d,%0d) last=%0b", x, y, last));
            return;
         end
         want = pixels_due.pop_front();
         if (x !== want.x) begin
            report_mismatch($sformatf("pixel_x %0d, expected %0d", x, want.x));
         end
         if (y !== want.y) begin
            report_mismatch($sformatf("pixel_y %0d, expected %0d", y, want.y));
         end
         if (last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b at (%0d,%0d)",
                                      last, want.last, want.x, want.y));
         end
      endtask
   endclass

   logic clock;
   logic reset;
   int   quiet_cycles = 0;

   lpg_req_if req_bus ();
   lpg_rsp_if rsp_bus ();

   line_scoreboard sb = new();

   line_pixel_generator #(
      .FRAME_SIZE(FRAME_SIZE)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Offer one segment after an idle gap and hold it until the block takes the word.
   task automatic send_segment(segment_type seg, int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.start_x <= seg.sx;
      req_bus.start_y <= seg.sy;
      req_bus.end_x   <= seg.ex;
      req_bus.end_y   <= seg.ey;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.rasterize_segment(seg);
   endtask

   // Hold off new segments until every pixel owed so far has come out.
   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   function automatic coord_type near_coord(coord_type base, int reach);
      int v;
      v = int'(base) + $urandom_range(0, 2 * reach) - reach;
      if (v < 0) begin
         v = 0;
      end else if (v > FRAME_SIZE - 1) begin
         v = FRAME_SIZE - 1;
      end
      return coord_type'(v);
   endfunction

   // Mostly free segments, with short ones, axis-aligned and diagonal ones,
   // and segments whose ends sit on the frame border.
   function automatic segment_type random_segment();
      segment_type seg;
      int          kind;
      int          span;
      kind   = $urandom_range(0, 9);
      seg.sx = coord_type'($urandom_range(0, FRAME_SIZE - 1));
      seg.sy = coord_type'($urandom_range(0, FRAME_SIZE - 1));
      seg.ex = coord_type'($urandom_range(0, FRAME_SIZE - 1));
      seg.ey = coord_type'($urandom_range(0, FRAME_SIZE - 1));
      if (kind >= 6 && kind <= 7) begin
         seg.ex = near_coord(seg.sx, 4);
         seg.ey = near_coord(seg.sy, 4);
      end else if (kind == 8) begin
         span = $urandom_range(0, FRAME_SIZE - 1);
         case ($urandom_range(0, 2))
            0: seg.ey = seg.sy;
            1: seg.ex = seg.sx;
            default: begin
               seg.ex = near_coord(seg.sx, span);
               seg.ey = (seg.ex > seg.sx) ? near_coord(seg.sy, 0) + (seg.ex - seg.sx)
                                          : seg.sy - (seg.sx - seg.ex);
               if (seg.ey > FRAME_SIZE - 1) begin
                  seg.ey = seg.sy;
               end
            end
         endcase
      end else if (kind == 9) begin
         seg.sx = $urandom_range(0, 1) ? coord_type'(FRAME_SIZE - 1) : '0;
         seg.ey = $urandom_range(0, 1) ? coord_type'(FRAME_SIZE - 1) : '0;
      end
      return seg;
   endfunction

   // Main sequence: reset, directed segments, random segments, final drain.
   initial begin
      segment_type directed[$];
      logic        burst;
      int          gap;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.start_x <= '0;
      req_bus.start_y <= '0;
      req_bus.end_x   <= '0;
      req_bus.end_y   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Zero length, full-frame axis lines, all four diagonals, decision ties
      // on both major axes, and one segment in every octant.
      directed = '{
         '{sx: 0,  sy: 0,  ex: 0,  ey: 0},  '{sx: 63, sy: 63, ex: 63, ey: 63},
         '{sx: 0,  sy: 0,  ex: 63, ey: 0},  '{sx: 63, sy: 0,  ex: 0,  ey: 0},
         '{sx: 0,  sy: 0,  ex: 0,  ey: 63}, '{sx: 0,  sy: 63, ex: 0,  ey: 0},
         '{sx: 0,  sy: 0,  ex: 63, ey: 63}, '{sx: 63, sy: 63, ex: 0,  ey: 0},
         '{sx: 0,  sy: 63, ex: 63, ey: 0},  '{sx: 63, sy: 0,  ex: 0,  ey: 63},
         '{sx: 10, sy: 10, ex: 12, ey: 11}, '{sx: 10, sy: 10, ex: 11, ey: 12},
         '{sx: 20, sy: 20, ex: 5,  ey: 27}, '{sx: 20, sy: 20, ex: 27, ey: 5},
         '{sx: 5,  sy: 40, ex: 60, ey: 30}, '{sx: 30, sy: 2,  ex: 25, ey: 61},
         '{sx: 0,  sy: 63, ex: 63, ey: 62}, '{sx: 63, sy: 0,  ex: 62, ey: 63},
         '{sx: 42, sy: 21, ex: 21, ey: 42}, '{sx: 1,  sy: 2,  ex: 4,  ey: 3},
         '{sx: 33, sy: 44, ex: 2,  ey: 30}, '{sx: 50, sy: 9,  ex: 37, ey: 58}
      };
      foreach (directed[i]) begin
         send_segment(directed[i], $urandom_range(0, 16));
      end

      burst = 1'b0;
      for (int i = 0; i < RANDOM_LINES; i++) begin
         if (i % 40 == 0) begin
            burst = $urandom_range(0, 3) == 0;
         end
         if (i == 150 || i == 300) begin
            drain_pixels();
         end
         gap = burst ? 0 : $urandom_range(0, 16);
         send_segment(random_segment(), gap);
      end
      req_bus.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Pixel sink: stalls a random number of cycles before each word, with stall-free bursts.
   initial begin
      int   stall;
      int   words;
      logic burst;
      rsp_bus.ready <= 1'b0;
      words = 0;
      burst = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (words % 100 == 0) begin
            burst = $urandom_range(0, 3) == 0;
         end
         stall = burst ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         sb.check_pixel(rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last);
         words++;
      end
   end

   // Watchdog: ends the run when no word moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

endmodule
